// ===== rtl/lpc_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the led pixel compositor
package lpc_pkg;

    // frame store geometry
    localparam int PIXEL_COUNT = 512;
    localparam int ADDR_W      = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int PIXEL_W     = 24;
    localparam int CHAN_W      = 8;
    localparam int IDX_W       = 9;
    localparam int SUM_W       = IDX_W + 1;
    localparam int CMP_W       = 13;
    localparam logic [CMP_W-1:0] PIXEL_LIMIT = CMP_W'(PIXEL_COUNT);

    // mode codes carried in the input word's tuser
    localparam logic [1:0] MODE_SET   = 2'd0;
    localparam logic [1:0] MODE_ADD   = 2'd1;
    localparam logic [1:0] MODE_BLEND = 2'd2;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_MUL,
        ST_MAC,
        ST_SQRT,
        ST_STORE,
        ST_WRITE
    } t_state;

    // shared arithmetic unit operations
    typedef enum logic [1:0] {
        ALU_NOP,
        ALU_MUL,
        ALU_MAC,
        ALU_SQRT
    } t_alu_op;

    typedef struct packed {
        t_alu_op           op;
        logic [CHAN_W-1:0] a;
        logic [CHAN_W-1:0] b;
        logic [2:0]        bit_idx;
    } t_alu_cmd;

endpackage

// ===== rtl/lpc_ram.sv =====
`timescale 1ns / 1ps
// generic single-port ram with registered read
module lpc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 512
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                       i_wdata,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/lpc_alu.sv =====
`timescale 1ns / 1ps
// shared 8x8 multiplier with accumulator, square root step and divide by 255
module lpc_alu
    import lpc_pkg::*;
(
    input  logic              i_clk,
    input  t_alu_cmd          i_cmd,
    output logic [CHAN_W-1:0] o_quot,
    output logic [CHAN_W-1:0] o_root
);

    logic [16:0]         r_acc;
    logic [CHAN_W-1:0]   r_root;
    logic [CHAN_W-1:0]   w_trial;
    logic [CHAN_W-1:0]   w_op_a;
    logic [CHAN_W-1:0]   w_op_b;
    logic [2*CHAN_W-1:0] w_prod;
    logic [16:0]         w_quot_sum;

    // operand select: a root step squares the trial root
    always_comb begin
        w_trial = r_root | (CHAN_W'(1) << i_cmd.bit_idx);
        if (i_cmd.op == ALU_SQRT) begin
            w_op_a = w_trial;
            w_op_b = w_trial;
        end else begin
            w_op_a = i_cmd.a;
            w_op_b = i_cmd.b;
        end
        w_prod = w_op_a * w_op_b;
    end

    // floor(p / 255) for p up to 255*255
    assign w_quot_sum = {1'b0, r_acc[15:0]} + 17'(r_acc[15:8]) + 17'd1;
    assign o_quot     = w_quot_sum[15:8];
    assign o_root     = r_root;

    // accumulator and root register; root steps test against half the sum
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            ALU_MUL: begin
                r_acc  <= {1'b0, w_prod};
                r_root <= '0;
            end
            ALU_MAC: begin
                r_acc <= r_acc + 17'(w_prod);
            end
            ALU_SQRT: begin
                if (w_prod <= r_acc[16:1]) begin
                    r_root <= w_trial;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/led_pixel_compositor_unit.sv =====
`timescale 1ns / 1ps
// led pixel compositor: frame store with set, additive and quadratic mean modes
// out of range goes straight to ST_WRITE; others take ST_READ, ST_LOAD, then ST_WRITE,
// and on add overflow and blend each channel runs ST_MUL (blend: ST_MAC, ST_SQRT steps)
// and ST_STORE on the shared multiplier before it; one word in flight, next word taken
// once the result is registered. synchronous active-low reset; afterwards the frame
// store is cleared one pixel a cycle with s_axis_tready low; config writes still taken.
module led_pixel_compositor_unit
    import lpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config: pixel_offset
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [8:0]  i_cfg_data,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // pixel_index, red_in, green_in, blue_in, zero pad
    input  logic [1:0]  s_axis_tuser,  // mode
    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // red_out, green_out, blue_out
    output logic [0:0]  m_axis_tuser   // out_of_range
);

    t_state            r_state;
    t_state            n_state;
    logic [IDX_W-1:0]  r_offset;
    logic [1:0]        r_mode;
    logic [ADDR_W-1:0] r_addr;
    logic              r_oor;
    logic [CHAN_W-1:0] r_new [3];
    logic [CHAN_W-1:0] r_old [3];
    logic [CHAN_W-1:0] r_res [3];
    logic [CHAN_W-1:0] r_head;
    logic [1:0]        r_ch;
    logic [2:0]        r_bit;
    logic [ADDR_W-1:0] r_clr;
    logic              r_out_valid;
    logic [23:0]       r_out_data;
    logic              r_out_oor;

    logic              w_accept;
    logic              w_out_free;
    logic [SUM_W-1:0]  w_sum;
    logic              w_oor;
    logic [CHAN_W-1:0] w_rd [3];
    logic [CHAN_W-1:0] w_mo;
    logic [CHAN_W-1:0] w_mn;
    logic [CHAN_W:0]   w_msum;
    logic              w_ram_we;
    logic [ADDR_W-1:0] w_ram_addr;
    logic [PIXEL_W-1:0] w_ram_wdata;
    logic [PIXEL_W-1:0] w_ram_rdata;
    t_alu_cmd          w_cmd;
    logic [CHAN_W-1:0] w_quot;
    logic [CHAN_W-1:0] w_root;

    // handshakes
    assign o_cfg_ready   = i_rst_n;
    assign s_axis_tready = (r_state == ST_IDLE) && i_rst_n;
    assign w_accept      = s_axis_tvalid & s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_oor;

    // address and range check
    assign w_sum = SUM_W'(s_axis_tdata[8:0]) + SUM_W'(r_offset);
    assign w_oor = (CMP_W'(w_sum) >= PIXEL_LIMIT);

    // stored pixel split and channel maxima
    always_comb begin
        w_rd[0] = w_ram_rdata[23:16];
        w_rd[1] = w_ram_rdata[15:8];
        w_rd[2] = w_ram_rdata[7:0];
        w_mo = (w_rd[0] > w_rd[1]) ? w_rd[0] : w_rd[1];
        w_mo = (w_mo > w_rd[2]) ? w_mo : w_rd[2];
        w_mn = (r_new[0] > r_new[1]) ? r_new[0] : r_new[1];
        w_mn = (w_mn > r_new[2]) ? w_mn : r_new[2];
        w_msum = {1'b0, w_mo} + {1'b0, w_mn};
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == ADDR_W'(PIXEL_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_oor ? ST_WRITE : ST_READ;
                end
            end
            ST_READ: n_state = ST_LOAD;
            ST_LOAD: begin
                if (r_mode == MODE_BLEND) begin
                    n_state = ST_MUL;
                end else if (r_mode == MODE_ADD && w_msum[CHAN_W]) begin
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_WRITE;
                end
            end
            ST_MUL: n_state = (r_mode == MODE_BLEND) ? ST_MAC : ST_STORE;
            ST_MAC: n_state = ST_SQRT;
            ST_SQRT: begin
                if (r_bit == 3'd0) begin
                    n_state = ST_STORE;
                end
            end
            ST_STORE: n_state = (r_ch == 2'd2) ? ST_WRITE : ST_MUL;
            ST_WRITE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs: ram port and arithmetic commands
    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_addr  = r_addr;
        w_ram_wdata = {r_res[0], r_res[1], r_res[2]};
        w_cmd.op      = ALU_NOP;
        w_cmd.a       = r_old[r_ch];
        w_cmd.b       = r_head;
        w_cmd.bit_idx = r_bit;
        case (r_state)
            ST_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_addr  = r_clr;
                w_ram_wdata = '0;
            end
            ST_MUL: begin
                w_cmd.op = ALU_MUL;
                if (r_mode == MODE_BLEND) begin
                    w_cmd.b = r_old[r_ch];
                end
            end
            ST_MAC: begin
                w_cmd.op = ALU_MAC;
                w_cmd.a  = r_new[r_ch];
                w_cmd.b  = r_new[r_ch];
            end
            ST_SQRT: w_cmd.op = ALU_SQRT;
            ST_WRITE: w_ram_we = w_out_free && !r_oor;
            default: begin
            end
        endcase
    end

    // state and config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_offset    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + ADDR_W'(1);
            end
            if (i_cfg_valid) begin
                r_offset <= i_cfg_data;
            end
            if (r_state == ST_WRITE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_mode   <= s_axis_tuser;
                    r_addr   <= ADDR_W'(w_sum);
                    r_oor    <= w_oor;
                    r_new[0] <= s_axis_tdata[16:9];
                    r_new[1] <= s_axis_tdata[24:17];
                    r_new[2] <= s_axis_tdata[32:25];
                end
            end
            ST_LOAD: begin
                r_ch   <= 2'd0;
                r_head <= 8'd255 - w_mn;
                for (int k = 0; k < 3; k++) begin
                    r_old[k] <= w_rd[k];
                    if (r_mode == MODE_ADD) begin
                        r_res[k] <= r_new[k] + w_rd[k];
                    end else begin
                        r_res[k] <= r_new[k];
                    end
                end
            end
            ST_MAC: r_bit <= 3'd7;
            ST_SQRT: r_bit <= r_bit - 3'd1;
            ST_STORE: begin
                if (r_mode == MODE_BLEND) begin
                    r_res[r_ch] <= w_root;
                end else begin
                    r_res[r_ch] <= w_quot + r_new[r_ch];
                end
                r_ch <= r_ch + 2'd1;
            end
            ST_WRITE: begin
                if (w_out_free) begin
                    r_out_oor  <= r_oor;
                    r_out_data <= r_oor ? 24'd0 : {r_res[2], r_res[1], r_res[0]};
                end
            end
            default: begin
            end
        endcase
    end

    lpc_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (PIXEL_COUNT)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    lpc_alu u_alu (
        .i_clk  (i_clk),
        .i_cmd  (w_cmd),
        .o_quot (w_quot),
        .o_root (w_root)
    );

    // an out-of-range word never reaches the frame store
    a_no_oor_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ram_we && r_state == ST_WRITE) |-> !r_oor)
        else $error("frame store written for an out-of-range pixel");

    // an out-of-range result carries a black colour
    a_oor_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == 24'd0))
        else $error("out-of-range result with nonzero colour");

    // an accepted word goes to a read or straight to the write-back
    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_READ || r_state == ST_WRITE))
        else $error("accepted word did not start processing");

    // channel counter never passes blue while arithmetic runs
    a_ch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL || r_state == ST_MAC || r_state == ST_SQRT
         || r_state == ST_STORE) |-> (r_ch != 2'd3))
        else $error("channel counter out of range");

endmodule

// ===== tb/lpc_checker.sv =====
`timescale 1ns / 1ps
// checker for the led pixel compositor: frame store prediction and result comparison
module lpc_checker
    import lpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [8:0]  i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [39:0] i_in_data,   // pixel_index, red_in, green_in, blue_in, zero pad
    input  logic [1:0]  i_in_mode,   // mode
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [23:0] i_out_data,  // red_out, green_out, blue_out
    input  logic [0:0]  i_out_flag,  // out_of_range
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       out_of_range;
    } t_pixel_result;

    // predicted frame store, {red, green, blue} per pixel
    logic [PIXEL_W-1:0] frame_model [PIXEL_COUNT];
    logic [8:0]         offset_model = '0;
    t_pixel_result      written_colors [$];
    int                 mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic logic [7:0] brightest(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        logic [7:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // floor of the square root of the floored mean of the squares
    function automatic logic [7:0] root_mean_square(logic [7:0] o, logic [7:0] n);
        int         mean_sq;
        logic [7:0] root;
        logic [7:0] trial;
        mean_sq = (int'(o) * int'(o) + int'(n) * int'(n)) / 2;
        root    = '0;
        for (int b = 7; b >= 0; b--) begin
            trial = root | (8'd1 << b);
            if (int'(trial) * int'(trial) <= mean_sq)
                root = trial;
        end
        return root;
    endfunction

    // apply one input word to the predicted store and return the written colour
    function automatic t_pixel_result compose_pixel(logic [1:0] mode, logic [39:0] data);
        logic [9:0]    addr;
        logic [7:0]    new_c [3];
        logic [7:0]    old_c [3];
        logic [7:0]    wr_c [3];
        logic [7:0]    old_top;
        logic [7:0]    new_top;
        t_pixel_result res;
        addr     = {1'b0, data[8:0]} + {1'b0, offset_model};
        new_c[0] = data[16:9];
        new_c[1] = data[24:17];
        new_c[2] = data[32:25];
        if (addr >= PIXEL_COUNT) begin
            res = '{red: 8'd0, green: 8'd0, blue: 8'd0, out_of_range: 1'b1};
            return res;
        end
        old_c[0] = frame_model[addr[ADDR_W-1:0]][23:16];
        old_c[1] = frame_model[addr[ADDR_W-1:0]][15:8];
        old_c[2] = frame_model[addr[ADDR_W-1:0]][7:0];
        case (mode)
            MODE_ADD: begin
                old_top = brightest(old_c[0], old_c[1], old_c[2]);
                new_top = brightest(new_c[0], new_c[1], new_c[2]);
                for (int k = 0; k < 3; k++) begin
                    // headroom scaling only when the brightest channels overflow
                    if (int'(old_top) + int'(new_top) > 255)
                        old_c[k] = 8'((int'(old_c[k]) * (255 - int'(new_top))) / 255);
                    wr_c[k] = new_c[k] + old_c[k];
                end
            end
            MODE_BLEND: begin
                for (int k = 0; k < 3; k++)
                    wr_c[k] = root_mean_square(old_c[k], new_c[k]);
            end
            default: begin
                // set, and the spare code behaves the same
                for (int k = 0; k < 3; k++)
                    wr_c[k] = new_c[k];
            end
        endcase
        frame_model[addr[ADDR_W-1:0]] = {wr_c[0], wr_c[1], wr_c[2]};
        res = '{red: wr_c[0], green: wr_c[1], blue: wr_c[2], out_of_range: 1'b0};
        return res;
    endfunction

    // watch the channels on every rising edge
    always @(posedge i_clk) begin
        t_pixel_result want;
        t_pixel_result got;
        if (!i_rst_n) begin
            for (int p = 0; p < PIXEL_COUNT; p++)
                frame_model[p] = '0;
            offset_model = '0;
            written_colors.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                offset_model = i_cfg_data;
            if (i_in_valid && i_in_ready)
                written_colors.push_back(compose_pixel(i_in_mode, i_in_data));
            if (i_out_valid && i_out_ready) begin
                got = '{red: i_out_data[7:0], green: i_out_data[15:8],
                        blue: i_out_data[23:16], out_of_range: i_out_flag[0]};
                if (written_colors.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result word r=%0d g=%0d b=%0d oor=%0b",
                                 $time, got.red, got.green, got.blue, got.out_of_range);
                    mismatches++;
                end else begin
                    want = written_colors.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue || got.out_of_range !== want.out_of_range) begin
                        if (mismatches < 10) begin
                            $display("%0t: result mismatch, expected r=%0d g=%0d b=%0d oor=%0b,",
                                     $time, want.red, want.green, want.blue,
                                     want.out_of_range);
                            $display("    got r=%0d g=%0d b=%0d oor=%0b",
                                     got.red, got.green, got.blue, got.out_of_range);
                        end
                        mismatches++;
                    end
                end
            end
        end
        o_pending <= written_colors.size();
    end

endmodule

// ===== tb/tb_led_pixel_compositor_unit.sv =====
`timescale 1ns / 1ps
// testbench top for the led pixel compositor: stimulus, flow control and verdict
module tb_led_pixel_compositor_unit;
    import lpc_pkg::*;

    localparam logic [1:0] MODE_SPARE    = 2'd3;
    localparam int         RANDOM_WORDS  = 107;
    localparam int         HOLD_CYCLES   = 320;
    localparam int         STALL_LIMIT   = 5000;
    localparam int         DRAIN_CYCLES  = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [8:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // pixel_index, red_in, green_in, blue_in, zero pad
    logic [1:0]  s_axis_tuser = '0;   // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // red_out, green_out, blue_out
    logic [0:0]  m_axis_tuser;        // out_of_range

    int fail_count;
    int pending;
    int quiet_cycles = 0;
    int sender_calm = 0;
    int sink_calm = 0;
    int results_taken = 0;
    int hot_base = 0;

    always #5 i_clk = ~i_clk;

    led_pixel_compositor_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    lpc_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_mode    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_flag   (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // wait cycles per word, with occasional runs of back-to-back words
    function automatic int draw_wait(ref int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
            calm = $urandom_range(8, 40);
        return $urandom_range(0, 11);
    endfunction

    // channel levels biased toward the extremes
    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 4))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom_range(0, 31));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [1:0] pick_mode();
        int r;
        r = $urandom_range(0, 19);
        if (r < 5)
            return MODE_SET;
        if (r < 12)
            return MODE_ADD;
        if (r < 19)
            return MODE_BLEND;
        return MODE_SPARE;
    endfunction

    // mostly a small hot window so pixels get revisited, sometimes anywhere
    function automatic logic [8:0] pick_index();
        if ($urandom_range(0, 4) == 0)
            return 9'($urandom_range(0, 511));
        return 9'(hot_base + $urandom_range(0, 15));
    endfunction

    // offer one word and hold it until taken; valid stays high on return
    task automatic send_word(logic [1:0] mode, logic [8:0] idx,
                             logic [7:0] red, logic [7:0] green, logic [7:0] blue);
        int gap;
        gap = draw_wait(sender_calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, blue, green, red, idx};
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // stop offering and wait until every result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // new pixel offset, written only with nothing in flight
    task automatic write_offset(logic [8:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        hot_base = (511 - int'(value) >= 15) ? $urandom_range(0, 496 - int'(value)) : 0;
    endtask

    // result sink with random stalls and two long hold-offs
    initial begin : result_sink
        int stall;
        forever begin
            stall = draw_wait(sink_calm);
            if (results_taken == 100 || results_taken == 480)
                stall = HOLD_CYCLES;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            results_taken++;
        end
    end

    // watchdog on cycles with no word moving on any channel
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // stimulus phases, one pixel offset each
    initial begin : stimulus
        int plan [7] = '{0, 511, 37, 496, 0, 200, 0};
        plan[6] = $urandom_range(1, 510);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < 7; ph++) begin
            write_offset(9'(plan[ph]));
            if (ph == 0) begin
                // full white then add with no overflow, then with headroom scaling
                send_word(MODE_SET,   9'd0,   8'd255, 8'd255, 8'd255);
                send_word(MODE_ADD,   9'd0,   8'd0,   8'd0,   8'd0);
                send_word(MODE_ADD,   9'd0,   8'd1,   8'd2,   8'd3);
                send_word(MODE_BLEND, 9'd0,   8'd255, 8'd0,   8'd128);
                // blend on a cleared pixel, with black and with white
                send_word(MODE_BLEND, 9'd5,   8'd0,   8'd0,   8'd0);
                send_word(MODE_BLEND, 9'd5,   8'd255, 8'd255, 8'd255);
                // last pixel, then a full-brightness add that scales old to zero
                send_word(MODE_SET,   9'd511, 8'd255, 8'd0,   8'd255);
                send_word(MODE_ADD,   9'd511, 8'd255, 8'd255, 8'd255);
                send_word(MODE_ADD,   9'd20,  8'd100, 8'd50,  8'd25);
                send_word(MODE_ADD,   9'd20,  8'd155, 8'd205, 8'd230);
                send_word(MODE_SPARE, 9'd10,  8'd18,  8'd52,  8'd200);
                send_word(MODE_SET,   9'd256, 8'd0,   8'd0,   8'd0);
                send_word(MODE_BLEND, 9'd256, 8'd1,   8'd1,   8'd1);
            end
            if (ph == 1) begin
                // largest offset: only index zero lands inside the store
                send_word(MODE_SET,   9'd0,   8'd9,   8'd8,   8'd7);
                send_word(MODE_ADD,   9'd1,   8'd255, 8'd255, 8'd255);
                send_word(MODE_BLEND, 9'd511, 8'd170, 8'd85,  8'd255);
                send_word(MODE_SPARE, 9'd256, 8'd1,   8'd128, 8'd254);
            end
            repeat (RANDOM_WORDS)
                send_word(pick_mode(), pick_index(), pick_level(), pick_level(), pick_level());
        end
        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lpc_pkg.sv
rtl/lpc_ram.sv
rtl/lpc_alu.sv
rtl/led_pixel_compositor_unit.sv
tb/lpc_checker.sv
tb/tb_led_pixel_compositor_unit.sv
